// ===== rtl/core/mte_pkg.sv =====
// Shared types, constants and widths for the MFM track sector extractor.
package mte_pkg;

  localparam int TRACK_BYTES  = 6400;
  localparam int SECTOR_BYTES = 256;

  localparam int POS_W    = 13;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SYNC_BYTE = 8'hA1;
  localparam logic [7:0] ID_MARK   = 8'hFE;
  localparam logic [7:0] DATA_MARK = 8'hFB;
  localparam logic [23:0] SYNC_RUN = {SYNC_BYTE, SYNC_BYTE, SYNC_BYTE};

  localparam int GAP_MIN  = 10;
  localparam int GAP_MAX  = 60;
  localparam int MARK_LEN = 3;

  localparam logic [1:0] ID_TRACK_BYTE  = 2'd3;
  localparam logic [1:0] ID_SIDE_BYTE   = 2'd2;
  localparam logic [1:0] ID_SECTOR_BYTE = 2'd1;

  localparam logic CFG_TRACKS  = 1'b0;
  localparam logic CFG_SECTORS = 1'b1;

  typedef struct packed {
    logic [7:0] tracks_per_side;
    logic [7:0] sector_count;
  } cfg_t;

  // One queued request: an optional byte to emit, then an optional capture start.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [7:0] count;
    logic       last;
    logic       start;
    logic [7:0] side;
    logic [7:0] track;
    logic [7:0] sector;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_ACC,
    BK_SUM
  } back_state_t;

endpackage

// ===== rtl/core/mte_front.sv =====
// Front end: track position, mark detection, ID collection and capture control.
module mte_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        track_byte,
  input  logic              track_start,
  input  mte_pkg::cfg_t     cfg,
  output logic              push,
  output mte_pkg::q_entry_t entry
);
  import mte_pkg::*;

  logic [23:0]      recent, recent_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             pend, pend_next;
  logic [1:0]       left, left_next;
  logic [7:0]       rec_side, rec_side_next;
  logic [7:0]       rec_track, rec_track_next;
  logic [7:0]       rec_sector, rec_sector_next;
  logic [POS_W-1:0] mark, mark_next;
  logic             cap, cap_next;
  logic [7:0]       cnt, cnt_next;

  always_comb begin
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] d;
    logic             sync;
    logic             last;
    recent_next     = recent;
    pos_next        = pos;
    pend_next       = pend;
    left_next       = left;
    rec_side_next   = rec_side;
    rec_track_next  = rec_track;
    rec_sector_next = rec_sector;
    mark_next       = mark;
    cap_next        = cap;
    cnt_next        = cnt;
    entry           = '0;
    push            = 1'b0;
    p               = '0;
    d               = '0;
    sync            = 1'b0;
    last            = 1'b0;
    if (accept) begin
      if (track_start) begin
        recent_next     = '0;
        pos_next        = '0;
        pend_next       = 1'b0;
        left_next       = '0;
        rec_side_next   = '0;
        rec_track_next  = '0;
        rec_sector_next = '0;
        mark_next       = '0;
        cap_next        = 1'b0;
        cnt_next        = '0;
      end
      p = pos_next;
      if (p >= POS_W'(TRACK_BYTES)) begin
        // overlong track: drop any ID in flight, hold the position
        pend_next = 1'b0;
        left_next = '0;
      end else begin
        if (cap_next) begin
          last        = (cnt_next >= 8'(SECTOR_BYTES - 1));
          entry.emit  = 1'b1;
          entry.data  = track_byte;
          entry.count = cnt_next;
          entry.last  = last;
          cnt_next    = cnt_next + 8'd1;
          if (last) begin
            cap_next = 1'b0;
          end
        end
        if (left_next != 2'd0) begin
          case (left_next)
            ID_TRACK_BYTE: rec_track_next = track_byte;
            ID_SIDE_BYTE:  rec_side_next  = track_byte;
            default: begin
              rec_sector_next = track_byte;
              if (track_byte >= 8'd1 && track_byte <= cfg.sector_count) begin
                pend_next = 1'b1;
              end
            end
          endcase
          left_next = left_next - 2'd1;
        end
        sync = (recent_next == SYNC_RUN);
        if (sync && track_byte == ID_MARK && p < POS_W'(TRACK_BYTES - 1)) begin
          pend_next = 1'b0;
          left_next = ID_TRACK_BYTE;
          mark_next = p - POS_W'(MARK_LEN);
        end else if (pend_next &&
                     {1'b0, p} >= {1'b0, mark_next} + (POS_W + 1)'(MARK_LEN)) begin
          d = p - POS_W'(MARK_LEN) - mark_next;
          if (sync && track_byte == DATA_MARK && d >= POS_W'(GAP_MIN) &&
              d < POS_W'(GAP_MAX) && p < POS_W'(TRACK_BYTES - SECTOR_BYTES - 1)) begin
            entry.start  = 1'b1;
            entry.side   = rec_side_next;
            entry.track  = rec_track_next;
            entry.sector = rec_sector_next;
            cap_next     = 1'b1;
            cnt_next     = '0;
            pend_next    = 1'b0;
          end else if (d >= POS_W'(GAP_MAX - 1)) begin
            pend_next = 1'b0;
          end
        end
        recent_next = {recent_next[15:0], track_byte};
        pos_next    = p + POS_W'(1);
      end
      push = entry.emit || entry.start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent     <= '0;
      pos        <= '0;
      pend       <= 1'b0;
      left       <= '0;
      rec_side   <= '0;
      rec_track  <= '0;
      rec_sector <= '0;
      mark       <= '0;
      cap        <= 1'b0;
      cnt        <= '0;
    end else begin
      recent     <= recent_next;
      pos        <= pos_next;
      pend       <= pend_next;
      left       <= left_next;
      rec_side   <= rec_side_next;
      rec_track  <= rec_track_next;
      rec_sector <= rec_sector_next;
      mark       <= mark_next;
      cap        <= cap_next;
      cnt        <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/mte_queue.sv =====
// Short request queue between the front end and the back end.
module mte_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mte_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output mte_pkg::q_entry_t  head,
  output mte_pkg::q_status_t status
);
  import mte_pkg::*;

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/mte_back.sv =====
// Back end: flat sector index arithmetic and the output register.
module mte_back (
  input  logic               clk,
  input  logic               rst,
  input  mte_pkg::cfg_t      cfg,
  input  mte_pkg::q_entry_t  head,
  input  mte_pkg::q_status_t qstat,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,
  output logic               m_tlast
);
  import mte_pkg::*;

  back_state_t state, state_next;
  logic        out_free;
  logic        load;
  logic        latch;

  logic [7:0]  side_r;
  logic [7:0]  track_r;
  logic [7:0]  sector_r;
  logic [15:0] prod_a;
  logic [16:0] part_t;
  logic [23:0] prod_m;
  logic [24:0] cur_index;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      BK_RUN:  state_next = latch ? BK_MUL : BK_RUN;
      BK_MUL:  state_next = BK_ACC;
      BK_ACC:  state_next = BK_SUM;
      BK_SUM:  state_next = BK_RUN;
      default: state_next = BK_RUN;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    load  = 1'b0;
    latch = 1'b0;
    case (state)
      BK_RUN: begin
        pop   = !qstat.empty && (!head.emit || out_free);
        load  = pop && head.emit;
        latch = pop && head.start;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      side_r   <= head.side;
      track_r  <= head.track;
      sector_r <= head.sector;
    end
    if (state == BK_MUL) begin
      prod_a <= 16'(side_r) * 16'(cfg.tracks_per_side);
      part_t <= 17'(16'(track_r) * 16'(cfg.sector_count)) + 17'(sector_r) - 17'd1;
    end
    if (state == BK_ACC) begin
      prod_m <= 24'(prod_a) * 24'(cfg.sector_count);
    end
    if (state == BK_SUM) begin
      cur_index <= 25'(prod_m) + 25'(part_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {head.data, head.count, cur_index[23:0]};
      m_tlast <= head.last;
    end
  end

endmodule

// ===== rtl/core/mfm_track_sector_extractor.sv =====
// Top level of the MFM track sector extractor: config registers and block wiring.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata = track_byte, tuser = track_start
//  m_*       out  tvalid/tready      tdata = sector_index, byte_index, sector_data;
//                                    tlast = sector_last
//  cfg_*     in   cfg_we             cfg_index selects the register, cfg_data value
//
// One track byte is taken per cycle while the request queue has room. A data
// mark that starts a capture sends the back end through its index arithmetic
// states BK_MUL, BK_ACC and BK_SUM in turn, popping nothing; the eight-entry queue
// soaks those up, so the input side stalls only when the queue fills.
// Reset (rst, synchronous) loads the config defaults and clears all track state.
// The output register lets the front keep working while a result waits.
module mfm_track_sector_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] track_byte
  input  logic        s_tuser,   // [0] track_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [23:0] sector_index, [31:24] byte_index,
                                 // [39:32] sector_data
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import mte_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      q_push;
  q_entry_t  q_in;
  q_entry_t  q_head;
  q_status_t q_stat;
  logic      q_pop;

  // config registers; write them only while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tracks_per_side <= 8'd80;
      cfg.sector_count    <= 8'd17;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACKS:  cfg.tracks_per_side <= cfg_data;
        CFG_SECTORS: cfg.sector_count    <= cfg_data;
        default:     cfg <= cfg;
      endcase
    end
  end

  // take a byte only when a request it may raise has a queue slot
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  mte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .track_byte  (s_tdata),
    .track_start (s_tuser),
    .cfg         (cfg),
    .push        (q_push),
    .entry       (q_in)
  );

  mte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  mte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (q_head),
    .qstat    (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // the last byte of a sector always carries the highest byte index
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[31:24] == 8'(SECTOR_BYTES - 1))
    else $error("sector end flagged at wrong byte index");

  // the back end never drains an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("request popped from empty queue");

  // a request is never dropped: a push implies the byte was accepted into room
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> accept && !q_stat.full)
    else $error("request pushed without room");

endmodule

// ===== bench/mfm_sector_checker.sv =====
// Watches the extractor's channels, predicts each sector byte and compares the outputs.
module mfm_sector_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          expect_left,
  output int          results_seen,
  output int          sectors_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mte_pkg::*;

  localparam logic [7:0] DEFAULT_TRACKS  = 8'd80;
  localparam logic [7:0] DEFAULT_SECTORS = 8'd17;

  typedef struct packed {
    logic [23:0] index;
    logic [7:0]  offset;
    logic [7:0]  data;
    logic        last;
  } sector_byte_t;

  sector_byte_t sector_bytes_due[$];

  logic [7:0]  cfg_tracks;
  logic [7:0]  cfg_sectors;

  logic [23:0] history;
  logic [12:0] pos;
  logic        id_armed;
  logic [1:0]  id_remaining;
  logic [7:0]  hdr_side;
  logic [7:0]  hdr_track;
  logic [7:0]  hdr_sector;
  logic [12:0] mark_pos;
  logic        capturing;
  logic [8:0]  cap_count;
  logic [24:0] cap_index;

  int fails;
  int seen;
  int sectors;

  task automatic clear_track();
    history      = '0;
    pos          = '0;
    id_armed     = 1'b0;
    id_remaining = '0;
    hdr_side     = '0;
    hdr_track    = '0;
    hdr_sector   = '0;
    mark_pos     = '0;
    capturing    = 1'b0;
    cap_count    = '0;
    cap_index    = '0;
  endtask

  // Advance the track model by one byte and queue the sector byte it yields, if any.
  task automatic predict_track_byte(input logic [7:0] b, input logic first);
    int p;
    int d;
    bit at_sync;
    sector_byte_t e;
    if (first) clear_track();
    p = int'(pos);
    if (p >= TRACK_BYTES) begin
      id_armed     = 1'b0;
      id_remaining = '0;
      return;
    end
    if (capturing) begin
      e.index  = cap_index[23:0];
      e.offset = cap_count[7:0];
      e.data   = b;
      e.last   = (int'(cap_count) >= SECTOR_BYTES - 1);
      sector_bytes_due.push_back(e);
      cap_count = cap_count + 9'd1;
      if (e.last) capturing = 1'b0;
    end
    if (id_remaining != 2'd0) begin
      case (id_remaining)
        ID_TRACK_BYTE: hdr_track = b;
        ID_SIDE_BYTE:  hdr_side  = b;
        ID_SECTOR_BYTE: begin
          hdr_sector = b;
          if (b >= 8'd1 && b <= cfg_sectors) id_armed = 1'b1;
        end
        default: ;
      endcase
      id_remaining = id_remaining - 2'd1;
    end
    at_sync = (history == SYNC_RUN);
    if (at_sync && b == ID_MARK && p + 1 < TRACK_BYTES) begin
      id_armed     = 1'b0;
      id_remaining = ID_TRACK_BYTE;
      mark_pos     = 13'(p - MARK_LEN);
    end else if (id_armed && p >= int'(mark_pos) + MARK_LEN) begin
      d = p - MARK_LEN - int'(mark_pos);
      if (at_sync && b == DATA_MARK && d >= GAP_MIN && d < GAP_MAX &&
          p + 1 < TRACK_BYTES - SECTOR_BYTES) begin
        cap_index = 25'(int'(hdr_side) * int'(cfg_tracks) * int'(cfg_sectors)
                        + int'(hdr_track) * int'(cfg_sectors) + int'(hdr_sector) - 1);
        capturing = 1'b1;
        cap_count = '0;
        id_armed  = 1'b0;
      end else if (d >= GAP_MAX - 1) begin
        id_armed = 1'b0;
      end
    end
    history = {history[15:0], b};
    pos     = 13'(p + 1);
  endtask

  always @(posedge clk) begin : monitor
    sector_byte_t head;
    if (rst) begin
      cfg_tracks  = DEFAULT_TRACKS;
      cfg_sectors = DEFAULT_SECTORS;
      clear_track();
      sector_bytes_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen++;
        if (m_tlast) sectors++;
        if (sector_bytes_due.size() == 0) begin
          $error("unexpected sector byte: index %0d byte %0d data %0h",
                 m_tdata[23:0], m_tdata[31:24], m_tdata[39:32]);
          fails++;
        end else begin
          head = sector_bytes_due.pop_front();
          if (m_tdata[23:0] !== head.index) begin
            $error("sector_index: expected %0d, got %0d", head.index, m_tdata[23:0]);
            fails++;
          end
          if (m_tdata[31:24] !== head.offset) begin
            $error("byte_index: expected %0d, got %0d", head.offset, m_tdata[31:24]);
            fails++;
          end
          if (m_tdata[39:32] !== head.data) begin
            $error("sector_data: expected %0h, got %0h", head.data, m_tdata[39:32]);
            fails++;
          end
          if (m_tlast !== head.last) begin
            $error("sector_last: expected %0b, got %0b", head.last, m_tlast);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRACKS:  cfg_tracks  = cfg_data;
          CFG_SECTORS: cfg_sectors = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_track_byte(s_tdata, s_tuser);
    end
    fail_count   <= fails;
    expect_left  <= sector_bytes_due.size();
    results_seen <= seen;
    sectors_seen <= sectors;
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the MFM track sector extractor: tracks, marks and register settings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mte_pkg::*;

  // Cycles to let the back end finish capture-start arithmetic after the last result.
  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 2;
  localparam int PHASE_ITEMS  = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] track_byte
  logic        s_tuser;    // [0] track_start
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // [23:0] sector_index, [31:24] byte_index, [39:32] sector_data
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int fail_count;
  int expect_left;
  int results_seen;
  int sectors_seen;

  // Stimulus bookkeeping: bytes sent into the current track, idle rates, totals.
  int trk_pos;
  int bytes_sent;
  int settings;
  int gap_pct;
  int ready_pct;
  bit quiet;

  always #5 clk = ~clk;

  mfm_track_sector_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mfm_sector_checker sector_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .expect_left  (expect_left),
    .results_seen (results_seen),
    .sectors_seen (sectors_seen)
  );

  // Send one track byte as a request: maybe idle first, then hold it until accepted.
  // The valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (first) trk_pos = 1;
    else trk_pos++;
    bytes_sent++;
  endtask

  // Filler that never contributes a sync byte, so directed marks land where intended.
  function automatic logic [7:0] gap_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SYNC_BYTE) b = 8'h4E;
    return b;
  endfunction

  task automatic send_fill(input int n);
    repeat (n) send_byte(gap_byte(), 1'b0);
  endtask

  task automatic send_data(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_mark(input logic [7:0] kind);
    repeat (MARK_LEN) send_byte(SYNC_BYTE, 1'b0);
    send_byte(kind, 1'b0);
  endtask

  // ID field order on the track: track, side, sector.
  task automatic send_id(input logic [7:0] trk, input logic [7:0] side, input logic [7:0] sec);
    send_mark(ID_MARK);
    send_byte(trk, 1'b0);
    send_byte(side, 1'b0);
    send_byte(sec, 1'b0);
  endtask

  // ID mark, gap so the data mark starts gap_len bytes after the ID mark, data mark, n bytes.
  task automatic send_sector(input logic [7:0] trk, input logic [7:0] side,
                             input logic [7:0] sec, input int gap_len, input int n);
    send_id(trk, side, sec);
    send_fill(gap_len - 7);
    send_mark(DATA_MARK);
    send_data(n);
  endtask

  // Drop the valid, wait for every expected sector byte, then let the back end settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expect_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only call while the block is idle.
  task automatic load_config(input logic [7:0] tracks, input logic [7:0] sectors);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRACKS;
    cfg_data  <= tracks;
    @(posedge clk);
    cfg_index <= CFG_SECTORS;
    cfg_data  <= sectors;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Result side: stall in bursts at a rate that drifts over the run.
  initial begin : ready_gen
    int hold;
    m_tready  = 1'b0;
    ready_pct = 20;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 255) == 0) begin
        case ($urandom_range(0, 2))
          0: ready_pct = 0;
          1: ready_pct = 20;
          default: ready_pct = 50;
        endcase
      end
      if (!quiet && $urandom_range(0, 99) < ready_pct) begin
        m_tready <= 1'b0;
        hold = $urandom_range(1, 7);
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int r;
    int gap_len;
    int n;
    int phase_start;
    logic [7:0] sec;
    logic [7:0] cur_sectors;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_TRACKS;
    cfg_data    = '0;
    trk_pos     = 0;
    bytes_sent  = 0;
    settings    = 1;
    gap_pct     = 20;
    quiet       = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed, reset settings (80 tracks, 17 sectors) ----
    send_byte(8'h4E, 1'b1);
    send_fill(20);
    // Shortest gap, lowest sector, data walks every byte value.
    send_id(8'd0, 8'd0, 8'd1);
    send_fill(3);
    send_mark(DATA_MARK);
    for (int i = 0; i < SECTOR_BYTES; i++) send_byte(8'(i), 1'b0);
    // Longest gap, highest valid sector.
    send_sector(8'd79, 8'd1, 8'd17, GAP_MAX - 1, 4);
    // Sector zero and one past the end: both must be dropped.
    send_sector(8'd5, 8'd0, 8'd0, 20, 0);
    send_fill(4);
    send_sector(8'd5, 8'd0, 8'd18, 20, 0);
    send_fill(4);
    // Data mark one byte too early, then one byte too late (the ID expires).
    send_sector(8'd1, 8'd0, 8'd2, GAP_MIN - 1, 0);
    send_fill(GAP_MAX);
    send_sector(8'd1, 8'd0, 8'd2, GAP_MAX, 0);
    send_fill(8);
    // Data mark with no ID ahead of it.
    send_mark(DATA_MARK);
    send_fill(10);
    // A newer ID replaces the pending one.
    send_id(8'd2, 8'd0, 8'd3);
    send_fill(5);
    send_sector(8'd2, 8'd0, 8'd4, 30, 4);
    // Fresh ID and data mark in the middle of a capture restart it.
    send_sector(8'd3, 8'd1, 8'd5, 20, 20);
    send_id(8'd3, 8'd1, 8'd6);
    send_fill(13);
    send_mark(DATA_MARK);
    send_data(20);
    // Track start in the middle of a capture abandons it.
    send_sector(8'd4, 8'd0, 8'd7, 25, 10);
    send_byte(8'h4E, 1'b1);
    send_fill(30);
    // Track start drops a pending ID and breaks a sync run spanning the boundary.
    send_id(8'd4, 8'd0, 8'd8);
    send_byte(8'h4E, 1'b1);
    send_fill(5);
    send_mark(DATA_MARK);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(SYNC_BYTE, 1'b1);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(ID_MARK, 1'b0);
    send_fill(10);

    // ---- Largest geometry: highest possible flat index ----
    drain();
    load_config(8'd255, 8'd255);
    send_byte(8'h00, 1'b1);
    send_fill(10);
    send_sector(8'd255, 8'd255, 8'd255, 30, 4);
    send_sector(8'd0, 8'd0, 8'd0, 30, 0);
    send_fill(10);

    // ---- Smallest geometry: only sector 1 is valid ----
    drain();
    load_config(8'd1, 8'd1);
    send_byte(8'hFF, 1'b1);
    send_fill(10);
    send_sector(8'd3, 8'd1, 8'd1, 15, 20);
    send_sector(8'd3, 8'd1, 8'd2, 15, 0);
    send_fill(10);

    // ---- Zero sectors per track: every ID is rejected ----
    drain();
    load_config(8'd80, 8'd0);
    send_byte(8'h4E, 1'b1);
    send_fill(10);
    send_sector(8'd0, 8'd0, 8'd1, 20, 0);
    send_sector(8'd0, 8'd0, 8'd0, 20, 0);
    send_fill(20);

    // ---- Random phases: mostly well-formed sectors, some noise and broken marks ----
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      cur_sectors = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(1, 20));
      load_config(8'($urandom_range(1, 255)), cur_sectors);
      // No idling on either side in the last phase.
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      send_byte(8'($urandom), 1'b1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_byte(8'($urandom), 1'b1);
        end else if (r < 65) begin
          send_fill($urandom_range(0, 30));
          sec     = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(1, cur_sectors));
          gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, GAP_MAX + 2)
                                                 : $urandom_range(GAP_MIN, GAP_MAX - 1);
          n       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SECTOR_BYTES - 1)
                                                 : SECTOR_BYTES;
          send_sector(8'($urandom), 8'($urandom), sec, gap_len, n);
        end else if (r < 80) begin
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 1'b0);
        end else if (r < 90) begin
          // Broken sync run: one to three sync bytes and an arbitrary tail.
          repeat ($urandom_range(1, 3)) send_byte(SYNC_BYTE, 1'b0);
          send_byte(($urandom_range(0, 1) == 0) ? DATA_MARK : 8'($urandom), 1'b0);
        end else begin
          send_id(8'($urandom), 8'($urandom), 8'($urandom));
          send_data($urandom_range(0, 70));
        end
      end
    end

    drain();
    $display("Covered %0d track bytes under %0d register settings, with mark-gap limits,",
             bytes_sent, settings);
    $display("track restarts and broken marks; %0d sector bytes checked, %0d sectors completed.",
             results_seen, sectors_seen);
    if (fail_count == 0 && expect_left == 0) begin
      $display("** mfm_track_sector_extractor: PASSED **");
    end else begin
      $display("** mfm_track_sector_extractor: FAILED **");
    end
    $finish;
  end

  // Hold a hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #20ms;
    $display("** mfm_track_sector_extractor: FAILED **");
    $finish;
  end

endmodule
